// File: design/aes_pkg.sv
package aes_pkg;

  localparam int unsigned RkWords = 60;
  localparam int unsigned RkAw = $clog2(RkWords);

  typedef enum logic [2:0] {
    CfgKeySize  = 3'd0,
    CfgKeyPart0 = 3'd1,
    CfgKeyPart1 = 3'd2,
    CfgKeyPart2 = 3'd3,
    CfgKeyPart3 = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StExpand,
    StRead,
    StRound,
    StDone
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  localparam logic [7:0] FwdBox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvBox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {FwdBox[w[31:24]], FwdBox[w[23:16]], FwdBox[w[15:8]], FwdBox[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(logic [31:0] c, logic inv);
    logic [7:0] a [4];
    logic [7:0] a2 [4];
    logic [7:0] a4 [4];
    logic [7:0] a8 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] r;
    for (int k = 0; k < 4; k++) begin
      a[k] = c[31-8*k -: 8];
      a2[k] = xt(a[k]);
      a4[k] = xt(a2[k]);
      a8[k] = xt(a4[k]);
      m2[k] = a2[k];
      m3[k] = a2[k] ^ a[k];
      m9[k] = a8[k] ^ a[k];
      mb[k] = a8[k] ^ a2[k] ^ a[k];
      md[k] = a8[k] ^ a4[k] ^ a[k];
      me[k] = a8[k] ^ a4[k] ^ a2[k];
    end
    for (int j = 0; j < 4; j++) begin
      if (inv) begin
        r[31-8*j -: 8] = me[j] ^ mb[(j+1)%4] ^ md[(j+2)%4] ^ m9[(j+3)%4];
      end else begin
        r[31-8*j -: 8] = m2[j] ^ m3[(j+1)%4] ^ a[(j+2)%4] ^ a[(j+3)%4];
      end
    end
    return r;
  endfunction

endpackage

// File: design/aes_ram.sv
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/aes_block_cipher.sv
// AES block cipher, 128/192/256-bit keys, encrypt or decrypt.
// Configuration: write cfg_we_i with cfg_idx_i (0 key size, 1..4 key parts)
// and cfg_data_i while the block is idle. Any valid write forces a new key
// expansion before the next block.
// Input channel in_valid_i/in_ready_o carries kind and the two data halves;
// output channel out_valid_o/out_ready_i carries the result.
// One block at a time: the key expansion, when due, first loads the Nk key
// words into the store, then takes Nr*4+4-Nk word steps (one store read,
// one word computed). A block then takes a read state per round to start
// the store read, then the four round key words one per cycle from the
// store's single read port; there are Nr+1 key additions in all.
// The result is held in an output register until taken; in_ready_o stays
// low until then. Reset clears the key registers to zero, the key size to
// 128 bits and marks the schedule as stale; the store itself is not cleared.
module aes_block_cipher (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aes_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aes_pkg::out_item_t  out_data_o
);
  import aes_pkg::*;

  state_e           state_q, state_d;
  logic [1:0]       size_q;
  logic [63:0]      kp_q [4];
  logic             ready_q;
  logic             kind_q, kind_d;
  logic [127:0]     st_q, st_d;
  logic [RkAw-1:0]  wi_q, wi_d;
  logic [RkAw-1:0]  ki_q, ki_d;
  logic [1:0]       col_q, col_d;
  logic [3:0]       rnd_q, rnd_d;
  logic             ph_q, ph_d;
  logic [31:0]      prev_q, prev_d;
  logic [3:0]       rc_q, rc_d;
  logic [7:0]       rcon_q, rcon_d;
  logic [127:0]     acc_q, acc_d;
  logic             out_v_q, out_v_d;
  logic [127:0]     res_q, res_d;

  logic             we;
  logic [RkAw-1:0]  waddr, raddr;
  logic [31:0]      wdata, rdata;

  logic [1:0]  es;
  logic [3:0]  nk;
  logic [3:0]  nr;
  logic [RkAw-1:0] total;

  always_comb begin
    es = (size_q == 2'd3) ? 2'd2 : size_q;
    if (RkWords < 60 && es == 2'd2) es = 2'd1;
    if (RkWords < 52 && es == 2'd1) es = 2'd0;
    nk = 4'd4 + {1'b0, es, 1'b0};
    nr = 4'd10 + {1'b0, es, 1'b0};
    total = RkAw'(4 * (11 + 2 * int'(es)));
  end

  aes_ram #(.Width(32), .Depth(RkWords)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= 2'd0;
      kp_q    <= '{default: '0};
      ready_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeySize: begin
          size_q  <= cfg_data_i[1:0];
          ready_q <= 1'b0;
        end
        CfgKeyPart0, CfgKeyPart1, CfgKeyPart2, CfgKeyPart3: begin
          kp_q[2'(cfg_idx_i - CfgKeyPart0)] <= cfg_data_i;
          ready_q <= 1'b0;
        end
        default: ;
      endcase
    end else if (state_q == StExpand && ph_q && wi_q == total - RkAw'(1)) begin
      ready_q <= 1'b1;
    end
  end

  logic [127:0] sb;
  logic [31:0]  t, kw;
  logic [31:0]  mcol;
  logic [1:0]   kidx;
  logic [1:0]   wsel;
  logic [63:0]  part;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    st_d    = st_q;
    wi_d    = wi_q;
    ki_d    = ki_q;
    col_d   = col_q;
    rnd_d   = rnd_q;
    ph_d    = ph_q;
    prev_d  = prev_q;
    rc_d    = rc_q;
    rcon_d  = rcon_q;
    acc_d   = acc_q;
    out_v_d = out_v_q;
    res_d   = res_q;
    we      = 1'b0;
    waddr   = wi_q;
    wdata   = '0;
    raddr   = ki_q;
    sb      = '0;
    t       = prev_q;
    kw      = '0;
    mcol    = '0;
    kidx    = '0;
    wsel    = wi_q[2:1];
    part    = kp_q[wsel];
    in_ready_o = (state_q == StIdle) && !out_v_q;

    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          kind_d = in_data_i.kind;
          st_d   = {in_data_i.data_high, in_data_i.data_low};
          rnd_d  = 4'd0;
          col_d  = 2'd0;
          if (!ready_q) begin
            wi_d    = '0;
            state_d = StLoad;
          end else begin
            ki_d    = in_data_i.kind ? RkAw'({nr, 2'b00}) : '0;
            state_d = StRead;
          end
        end
      end
      StLoad: begin
        we    = 1'b1;
        wdata = wi_q[0] ? part[31:0] : part[63:32];
        prev_d = wdata;
        wi_d  = wi_q + RkAw'(1);
        if (wi_q == RkAw'(nk - 4'd1)) begin
          rc_d    = 4'd0;
          rcon_d  = 8'h01;
          ph_d    = 1'b0;
          state_d = StExpand;
        end
      end
      StExpand: begin
        raddr = wi_q - RkAw'(nk);
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (rc_q == 4'd0) begin
            t = sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rcon_q, 24'h0};
            rcon_d = xt(rcon_q);
          end else if (nk == 4'd8 && rc_q == 4'd4) begin
            t = sub_word(prev_q);
          end
          we     = 1'b1;
          wdata  = rdata ^ t;
          prev_d = wdata;
          rc_d   = (rc_q == nk - 4'd1) ? 4'd0 : rc_q + 4'd1;
          wi_d   = wi_q + RkAw'(1);
          if (wi_q == total - RkAw'(1)) begin
            ki_d    = kind_q ? RkAw'({nr, 2'b00}) : '0;
            state_d = StRead;
          end
        end
      end
      StRead: begin
        ki_d    = ki_q + RkAw'(1);
        col_d   = 2'd0;
        state_d = StRound;
      end
      StRound: begin
        kw = rdata;
        acc_d[127-32*col_q -: 32] = st_q[127-32*col_q -: 32] ^ kw;
        ki_d  = ki_q + RkAw'(1);
        col_d = col_q + 2'd1;
        if (col_q == 2'd3) begin
          // acc_d holds state after key add
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
              kidx = kind_q ? 2'((c + 4 - r) % 4) : 2'((c + r) % 4);
              sb[127-32*c-8*r -: 8] = kind_q ? InvBox[acc_d[127-32*kidx-8*r -: 8]]
                                             : FwdBox[acc_d[127-32*kidx-8*r -: 8]];
            end
          end
          rnd_d = rnd_q + 4'd1;
          if (rnd_q == nr) begin
            res_d   = acc_d;
            out_v_d = 1'b1;
            state_d = StIdle;
          end else begin
            if (kind_q) begin
              if (rnd_q == 4'd0) begin
                st_d = sb;
              end else begin
                for (int c = 0; c < 4; c++) begin
                  mcol = mix_col(acc_d[127-32*c -: 32], 1'b1);
                  sb[127-32*c -: 32] = 32'h0;
                  st_d[127-32*c -: 32] = mcol;
                end
                for (int c = 0; c < 4; c++) begin
                  for (int r = 0; r < 4; r++) begin
                    kidx = 2'((c + 4 - r) % 4);
                    sb[127-32*c-8*r -: 8] = InvBox[st_d[127-32*kidx-8*r -: 8]];
                  end
                end
                st_d = sb;
              end
              ki_d = ki_q - RkAw'(8);
            end else begin
              ki_d = ki_q;
              if (rnd_q == nr - 4'd1) begin
                st_d = sb;
              end else begin
                for (int c = 0; c < 4; c++) begin
                  st_d[127-32*c -: 32] = mix_col(sb[127-32*c -: 32], 1'b0);
                end
              end
            end
            state_d = StRead;
          end
        end
      end
      default: state_d = StIdle;
    endcase

    if (state_q == StRound) begin
      raddr = ki_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    st_q   <= st_d;
    wi_q   <= wi_d;
    ki_q   <= ki_d;
    col_q  <= col_d;
    rnd_q  <= rnd_d;
    ph_q   <= ph_d;
    prev_q <= prev_d;
    rc_q   <= rc_d;
    rcon_q <= rcon_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = '{result_high: res_q[127:64], result_low: res_q[63:0]};

endmodule

// File: design/aes_checker.sv
module aes_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input aes_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("ready while result pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("no work after transfer");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result after reset");

endmodule

bind aes_block_cipher aes_checker u_aes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: dv/tb_aes_block_cipher.sv
module tb_aes_block_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_pkg::*;

  class aes_result_board;
    out_item_t expected_q[$];
    int        mismatch_cnt;
    int        checked_cnt;

    function void note_block(out_item_t want);
      expected_q.push_back(want);
    endfunction

    task check_block(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no block pending", 64'h0, got.result_high);
        return;
      end
      want = expected_q.pop_front();
      checked_cnt++;
      if (got.result_high !== want.result_high) begin
        report_mismatch("result_high", want.result_high, got.result_high);
      end
      if (got.result_low !== want.result_low) begin
        report_mismatch("result_low", want.result_low, got.result_low);
      end
    endtask

    task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatch_cnt++;
      $display("MISMATCH %s: expected %h got %h", what, want, got);
    endtask
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = CfgKeySize;
  logic [63:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  aes_block_cipher u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  aes_result_board board = new();

  logic [1:0]  key_size_q;
  logic [63:0] key_part_q [4];
  logic [31:0] sched_w [60];
  logic        sched_valid;
  bit          steady_phase;
  int          cycle_cnt;
  int          block_cnt;
  int          size_used [3];
  int          kind_used [2];

  localparam int unsigned CycleLimit = 400000;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic int unsigned active_size();
    return (key_size_q == 2'd3) ? 2 : key_size_q;
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) r[8*b +: 8] = FwdBox[w[8*b +: 8]];
    return r;
  endfunction

  task automatic build_schedule();
    int unsigned nk;
    int unsigned total;
    logic [31:0] t;
    logic [7:0]  rc;
    nk = 4 + 2 * active_size();
    total = 4 * (11 + 2 * active_size());
    for (int i = 0; i < nk; i++) begin
      sched_w[i] = i[0] ? key_part_q[i / 2][31:0] : key_part_q[i / 2][63:32];
    end
    rc = 8'h01;
    for (int i = nk; i < total; i++) begin
      t = sched_w[i - 1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (nk == 8 && i % nk == 4) begin
        t = sbox_word(t);
      end
      sched_w[i] = sched_w[i - nk] ^ t;
    end
    sched_valid = 1'b1;
  endtask

  function automatic void add_round(ref logic [7:0] s[16], input int unsigned rnd);
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) s[4 * c + r] ^= sched_w[4 * rnd + c][31 - 8 * r -: 8];
    end
  endfunction

  function automatic void sub_rows(ref logic [7:0] s[16], input bit inv);
    logic [7:0] t[16];
    int unsigned src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        t[4 * c + r] = inv ? InvBox[s[4 * src + r]] : FwdBox[s[4 * src + r]];
      end
    end
    s = t;
  endfunction

  function automatic void mix_cols(ref logic [7:0] s[16], input bit inv);
    logic [7:0] m[4];
    logic [7:0] col[4];
    logic [7:0] acc;
    if (inv) begin
      m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    end else begin
      m = '{8'h02, 8'h03, 8'h01, 8'h01};
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = s[4 * c + k];
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= gmul(m[(k + 4 - r) % 4], col[k]);
        s[4 * c + r] = acc;
      end
    end
  endfunction

  task automatic cipher_block(input in_item_t item, output out_item_t res);
    logic [7:0]  s[16];
    int unsigned nr;
    if (!sched_valid) build_schedule();
    nr = 10 + 2 * active_size();
    for (int i = 0; i < 8; i++) begin
      s[i] = item.data_high[63 - 8 * i -: 8];
      s[8 + i] = item.data_low[63 - 8 * i -: 8];
    end
    if (!item.kind) begin
      add_round(s, 0);
      for (int rnd = 1; rnd < nr; rnd++) begin
        sub_rows(s, 1'b0);
        mix_cols(s, 1'b0);
        add_round(s, rnd);
      end
      sub_rows(s, 1'b0);
      add_round(s, nr);
    end else begin
      add_round(s, nr);
      for (int rnd = nr - 1; rnd >= 1; rnd--) begin
        sub_rows(s, 1'b1);
        add_round(s, rnd);
        mix_cols(s, 1'b1);
      end
      sub_rows(s, 1'b1);
      add_round(s, 0);
    end
    for (int i = 0; i < 8; i++) begin
      res.result_high[63 - 8 * i -: 8] = s[i];
      res.result_low[63 - 8 * i -: 8] = s[8 + i];
    end
  endtask

  function automatic bit idle_now();
    return !steady_phase && ($urandom_range(99) < 32);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgKeySize) begin
      key_size_q = value[1:0];
      sched_valid = 1'b0;
    end else if (idx <= CfgKeyPart3) begin
      key_part_q[idx - 1] = value;
      sched_valid = 1'b0;
    end
  endtask

  task automatic load_key(input logic [1:0] size, input logic [63:0] p0, input logic [63:0] p1,
                          input logic [63:0] p2, input logic [63:0] p3);
    while (board.expected_q.size() != 0) @(negedge clk_i);
    write_reg(CfgKeySize, {62'h0, size});
    write_reg(CfgKeyPart0, p0);
    write_reg(CfgKeyPart1, p1);
    write_reg(CfgKeyPart2, p2);
    write_reg(CfgKeyPart3, p3);
  endtask

  task automatic send_block(input logic kind, input logic [63:0] hi, input logic [63:0] lo);
    in_item_t  item;
    out_item_t want;
    item = '{kind: kind, data_high: hi, data_low: lo};
    @(negedge clk_i);
    while (idle_now()) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cipher_block(item, want);
    board.note_block(want);
    block_cnt++;
    size_used[active_size()]++;
    kind_used[kind]++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(5))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= !idle_now();
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_block(out_data_o);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("aes_block_cipher verification failed");
      $finish;
    end
  end

  initial begin
    logic [1:0] sz;
    steady_phase = 1'b0;
    key_size_q = 2'd0;
    for (int i = 0; i < 4; i++) key_part_q[i] = '0;
    sched_valid = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset key: all zero, 128-bit
    send_block(1'b0, 64'h0, 64'h0);
    send_block(1'b1, '1, '1);
    load_key(2'd0, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '1, '1);
    send_block(1'b0, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_block(1'b1, 64'h3925841d02dc09fb, 64'hdc118597196a0b32);
    load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
    load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    load_key(2'd3, '1, '1, '1, '1);
    send_block(1'b0, '1, '1);
    send_block(1'b1, 64'h0, 64'h0);
    send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
    while (board.expected_q.size() != 0) @(negedge clk_i);
    write_reg(3'd7, 64'h0);
    write_reg(3'd5, '1);
    send_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210);

    for (int ph = 0; ph < 12; ph++) begin
      sz = (ph < 3) ? ph[1:0] : 2'($urandom_range(3));
      load_key(sz, rand64(), rand64(), rand64(), rand64());
      steady_phase = (ph == 5);
      for (int n = 0; n < 100; n++) begin
        send_block(1'($urandom_range(1)), rand64(), rand64());
      end
    end
    steady_phase = 1'b0;

    while (board.expected_q.size() != 0) @(negedge clk_i);
    repeat (70) @(negedge clk_i);
    $display("%0d blocks sent: %0d/%0d/%0d under 128/192/256-bit keys, %0d encrypt, %0d decrypt",
             block_cnt, size_used[0], size_used[1], size_used[2], kind_used[0], kind_used[1]);
    $display("%0d results checked, %0d mismatches", board.checked_cnt, board.mismatch_cnt);
    if (board.mismatch_cnt == 0 && board.expected_q.size() == 0) begin
      $display("aes_block_cipher verification clean");
    end else begin
      $display("aes_block_cipher verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/aes_pkg.sv
design/aes_ram.sv
design/aes_block_cipher.sv
design/aes_checker.sv
dv/tb_aes_block_cipher.sv
